### src/bgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// shared constants and types of the baseline geometric delay pipeline
// ----------------------------------------------------------------------------
package bgd_pkg;

    // pi in q30, truncated
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    // one in q31
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    // earth rotation rate in q47 rad/s
    localparam logic [33:0] OMEGA_Q47 = 34'((64'd3373259426 << 18) / 64'd86400);
    // light speed in 2^-24 m/s
    localparam logic [52:0] LIGHT_Q24 = 53'(64'd299792458 << 24);
    // ns per s, both output scales are this times a power of two
    localparam logic [29:0] GIGA      = 30'd1000000000;

    // horner divisors of the two series
    localparam int unsigned SIN_STEPS = 4;
    localparam int unsigned COS_STEPS = 5;
    localparam int unsigned SIN_DIVS [SIN_STEPS] = '{72, 42, 20, 6};
    localparam int unsigned COS_DIVS [COS_STEPS] = '{90, 56, 30, 12, 2};

    // register stages of one sine/cosine unit
    localparam int unsigned SC_LAT = 3 * COS_STEPS + 3;

    // divider geometry
    localparam int unsigned DIV_QB = 47;
    localparam int unsigned DEN_W  = 53;

    // signed q31 trig value in [-1, 1]
    typedef logic signed [32:0] q31_t;

endpackage

### src/bgd_horner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_horner
// pipelined horner chain p = 1 - x2*p/k, three stages per term
// ----------------------------------------------------------------------------
module bgd_horner #(
    parameter int unsigned NSTEP = 4,
    parameter int unsigned DIVS [NSTEP] = '{72, 42, 20, 6}
) (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] x2,
    output logic [31:0] poly
);

    logic [30:0] t_reg  [NSTEP];
    logic [30:0] q_reg  [NSTEP];
    logic [31:0] p_reg  [NSTEP];
    logic [30:0] xa_reg [NSTEP];
    logic [30:0] xb_reg [NSTEP];
    logic [30:0] xc_reg [NSTEP];

    genvar j;
    generate
        for (j = 0; j < NSTEP; j++)
        begin : g_step
            // exact reciprocal for a 31 bit dividend
            localparam int unsigned L = $clog2(DIVS[j]);
            localparam int unsigned S = 31 + L;
            localparam logic [63:0] MW = ((64'd1 << S) + 64'(DIVS[j]) - 64'd1)
                                         / 64'(DIVS[j]);
            localparam logic [31:0] M = MW[31:0];

            logic [31:0] p_src;
            logic [30:0] x_src;
            logic [62:0] prod_a;
            logic [62:0] prod_b;

            if (j == 0)
            begin : g_first
                assign p_src = bgd_pkg::ONE_Q31;
                assign x_src = x2;
            end
            else
            begin : g_next
                assign p_src = p_reg[j-1];
                assign x_src = xc_reg[j-1];
            end

            assign prod_a = 63'(x_src) * 63'(p_src);
            assign prod_b = 63'(t_reg[j]) * 63'(M);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t_reg[j]  <= prod_a[61:31];
                    xa_reg[j] <= x_src;
                    q_reg[j]  <= 31'(prod_b >> S);
                    xb_reg[j] <= xa_reg[j];
                    p_reg[j]  <= bgd_pkg::ONE_Q31 - {1'b0, q_reg[j]};
                    xc_reg[j] <= xb_reg[j];
                end
            end
        end
    endgenerate

    assign poly = p_reg[NSTEP-1];

endmodule

### src/bgd_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_sincos
// pipelined sine and cosine of a turn fraction, q31 results
// ----------------------------------------------------------------------------
module bgd_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        turn,
    output bgd_pkg::q31_t      sin_val,
    output bgd_pkg::q31_t      cos_val
);

    localparam int unsigned SIN_LAT = 3 * bgd_pkg::SIN_STEPS;
    localparam int unsigned COS_LAT = 3 * bgd_pkg::COS_STEPS;
    localparam int unsigned PAD     = COS_LAT - SIN_LAT - 1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [29:0] u;
    logic        swap;
    logic [30:0] y31;
    logic [29:0] y;
    logic [61:0] x_prod;
    logic [61:0] x2_prod;
    logic [62:0] s_prod;

    logic [30:0] x1_reg;
    logic [1:0]  q1_reg;
    logic        sw1_reg;
    logic [30:0] x2_reg;
    logic [30:0] x2x_reg;
    logic [1:0]  q2_reg;
    logic        sw2_reg;
    logic [30:0] xd_reg  [SIN_LAT];
    logic [1:0]  qd_reg  [COS_LAT];
    logic        swd_reg [COS_LAT];
    logic [31:0] s0_reg;
    logic [31:0] sd_reg  [PAD];
    bgd_pkg::q31_t sin_reg;
    bgd_pkg::q31_t cos_reg;

    logic [31:0] p_sin;
    logic [31:0] p_cos;
    bgd_pkg::q31_t a_val;
    bgd_pkg::q31_t b_val;
    bgd_pkg::q31_t sin_next;
    bgd_pkg::q31_t cos_next;

    // fold into the first half of a quadrant
    assign u      = turn[29:0];
    assign swap   = u > 30'h2000_0000;
    assign y31    = 31'h4000_0000 - {1'b0, u};
    assign y      = swap ? y31[29:0] : u;
    assign x_prod = 62'(y) * 62'(bgd_pkg::PI_Q30);
    assign x2_prod = 62'(x1_reg) * 62'(x1_reg);

    bgd_horner #(
        .NSTEP (bgd_pkg::SIN_STEPS),
        .DIVS  (bgd_pkg::SIN_DIVS)
    ) u_sin (
        .clk  (clk),
        .en   (en),
        .x2   (x2_reg),
        .poly (p_sin)
    );

    bgd_horner #(
        .NSTEP (bgd_pkg::COS_STEPS),
        .DIVS  (bgd_pkg::COS_DIVS)
    ) u_cos (
        .clk  (clk),
        .en   (en),
        .x2   (x2_reg),
        .poly (p_cos)
    );

    assign s_prod = 63'(xd_reg[SIN_LAT-1]) * 63'(p_sin);

    always_comb
    begin
        a_val = swd_reg[COS_LAT-1] ? $signed({1'b0, p_cos}) : $signed({1'b0, sd_reg[PAD-1]});
        b_val = swd_reg[COS_LAT-1] ? $signed({1'b0, sd_reg[PAD-1]}) : $signed({1'b0, p_cos});
        unique case (qd_reg[COS_LAT-1])
            QUAD_0:
            begin
                sin_next = a_val;
                cos_next = b_val;
            end
            QUAD_1:
            begin
                sin_next = b_val;
                cos_next = -a_val;
            end
            QUAD_2:
            begin
                sin_next = -a_val;
                cos_next = -b_val;
            end
            QUAD_3:
            begin
                sin_next = -b_val;
                cos_next = a_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x_prod[60:30];
            q1_reg  <= turn[31:30];
            sw1_reg <= swap;
            x2_reg  <= x2_prod[61:31];
            x2x_reg <= x1_reg;
            q2_reg  <= q1_reg;
            sw2_reg <= sw1_reg;
            xd_reg[0]  <= x2x_reg;
            for (int i = 1; i < SIN_LAT; i++)
            begin
                xd_reg[i] <= xd_reg[i-1];
            end
            qd_reg[0]  <= q2_reg;
            swd_reg[0] <= sw2_reg;
            for (int i = 1; i < COS_LAT; i++)
            begin
                qd_reg[i]  <= qd_reg[i-1];
                swd_reg[i] <= swd_reg[i-1];
            end
            s0_reg    <= s_prod[62:31];
            sd_reg[0] <= s0_reg;
            for (int i = 1; i < PAD; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

### src/bgd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bgd_divider #(
    parameter int unsigned NW = 99,
    parameter int unsigned QB = 47,
    parameter int unsigned DW = 53
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic          neg_in,
    output logic [QB-1:0] quo,
    output logic          neg_out
);

    logic [DW-1:0] r_reg [QB];
    logic [QB-1:0] q_reg [QB];
    logic [QB-1:0] n_reg [QB];
    logic [DW-1:0] d_reg [QB];
    logic          g_reg [QB];

    genvar i;
    generate
        for (i = 0; i < QB; i++)
        begin : g_stage
            logic [DW-1:0] r_src;
            logic [QB-1:0] q_src;
            logic [QB-1:0] n_src;
            logic [DW-1:0] d_src;
            logic          g_src;
            logic [DW:0]   t_val;
            logic [DW:0]   t_sub;
            logic          ge;

            if (i == 0)
            begin : g_first
                // top part of the dividend is below the divisor
                assign r_src = DW'(num[NW-1:QB]);
                assign q_src = '0;
                assign n_src = num[QB-1:0];
                assign d_src = den;
                assign g_src = neg_in;
            end
            else
            begin : g_next
                assign r_src = r_reg[i-1];
                assign q_src = q_reg[i-1];
                assign n_src = n_reg[i-1];
                assign d_src = d_reg[i-1];
                assign g_src = g_reg[i-1];
            end

            assign t_val = {r_src, n_src[QB-1]};
            assign t_sub = t_val - {1'b0, d_src};
            assign ge    = t_val >= {1'b0, d_src};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[i] <= ge ? t_sub[DW-1:0] : t_val[DW-1:0];
                    q_reg[i] <= {q_src[QB-2:0], ge};
                    n_reg[i] <= {n_src[QB-2:0], 1'b0};
                    d_reg[i] <= d_src;
                    g_reg[i] <= g_src;
                end
            end
        end
    endgenerate

    assign quo     = q_reg[QB-1];
    assign neg_out = g_reg[QB-1];

endmodule

### src/baseline_geometric_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baseline_geometric_delay
// geometric delay and delay rate of one baseline toward one source
// ----------------------------------------------------------------------------
// The block takes one item per clock unless its output stalls, and gives
// one result per item, in order. Hour angle and declination go
// through two pipelined sine/cosine units (18 stages, Horner series with
// exact reciprocal division), the baseline is projected onto w and its
// rate, and the delay and rate are each divided by the light speed seen by
// the end point in a 47 stage restoring divider, one quotient bit a stage;
// those dividers set the latency. Every unit is fully pipelined, so the
// sustained rate is one item per cycle. When the output item is not taken
// the whole pipeline holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module baseline_geometric_delay (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hour_angle[31:0], declination[63:32], end_x[103:64], end_y[143:104],
    // end_z[183:144], origin_x[223:184], origin_y[263:224],
    // origin_z[303:264], motion_correct[304], zero pad
    input  logic [311:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // delay_ns[42:0], delay_rate[79:43], saturated[80], zero pad
    output logic [87:0]  m_tdata
);

    localparam int unsigned SC  = bgd_pkg::SC_LAT;
    localparam int unsigned QB  = bgd_pkg::DIV_QB;
    localparam int unsigned DW  = bgd_pkg::DEN_W;
    localparam int unsigned LAT = SC + 9 + QB + 1;
    // valid index of the denominator stage
    localparam int unsigned DEN_STG = SC + 7;

    localparam logic signed [47:0] DLY_MAX = 48'sd4398046511103;
    localparam logic signed [47:0] DLY_MIN = -48'sd4398046511104;
    localparam logic signed [47:0] RTE_MAX = 48'sd68719476735;
    localparam logic signed [47:0] RTE_MIN = -48'sd68719476736;

    typedef struct packed {
        logic signed [40:0] dx;
        logic signed [40:0] dy;
        logic signed [40:0] dz;
        logic signed [39:0] ex;
        logic signed [39:0] ey;
        logic               mc;
    } crd_t;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] t;
        t = v[32] ? 33'(-v) : 33'(v);
        return t[31:0];
    endfunction

    function automatic logic [40:0] mag41(input logic signed [40:0] v);
        logic [40:0] t;
        t = v[40] ? 41'(-v) : 41'(v);
        return t;
    endfunction

    function automatic logic [52:0] mag53(input logic signed [52:0] v);
        logic [52:0] t;
        t = v[52] ? 53'(-v) : 53'(v);
        return t;
    endfunction

    // pipeline control
    logic en;
    logic vld_reg [LAT];

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // trig units
    bgd_pkg::q31_t sha, cha, sdec, cdec;

    bgd_sincos u_ha (
        .clk     (clk),
        .en      (en),
        .turn    (s_tdata[31:0]),
        .sin_val (sha),
        .cos_val (cha)
    );

    bgd_sincos u_dec (
        .clk     (clk),
        .en      (en),
        .turn    (s_tdata[63:32]),
        .sin_val (sdec),
        .cos_val (cdec)
    );

    // baseline difference, carried alongside the trig units
    crd_t crd_in;
    crd_t crd_reg [SC];

    always_comb
    begin
        crd_in.dx = 41'($signed(s_tdata[103:64]))  - 41'($signed(s_tdata[223:184]));
        crd_in.dy = 41'($signed(s_tdata[143:104])) - 41'($signed(s_tdata[263:224]));
        crd_in.dz = 41'($signed(s_tdata[183:144])) - 41'($signed(s_tdata[303:264]));
        crd_in.ex = $signed(s_tdata[103:64]);
        crd_in.ey = $signed(s_tdata[143:104]);
        crd_in.mc = s_tdata[304];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crd_reg[0] <= crd_in;
            for (int i = 1; i < SC; i++)
            begin
                crd_reg[i] <= crd_reg[i-1];
            end
        end
    end

    // stage p1: cos(dec) times sin/cos(ha), magnitudes
    logic [63:0]   pms_reg, pmc_reg;
    logic          ngs_reg, ngc_reg;
    bgd_pkg::q31_t sdec1_reg;
    crd_t          crd1_reg;

    // stage p2: rounded direction coefficients
    bgd_pkg::q31_t ps_reg, pc_reg, sdec2_reg;
    crd_t          crd2_reg;
    logic [63:0]   rs_sum, rc_sum;
    logic signed [32:0] rs_mag, rc_mag;

    assign rs_sum = pms_reg + 64'h4000_0000;
    assign rc_sum = pmc_reg + 64'h4000_0000;
    assign rs_mag = $signed({1'b0, rs_sum[62:31]});
    assign rc_mag = $signed({1'b0, rc_sum[62:31]});

    // stage p3: coordinate partial products
    // terms: pc*dx, ps*dy, sdec*dz, ps*dx, pc*dy, ps*ex, pc*ey
    bgd_pkg::q31_t      ca [7];
    logic signed [40:0] cb [7];
    logic [63:0]        plo_next [7];
    logic [40:0]        phi_next [7];
    logic               png_next [7];
    logic [63:0]        plo_reg [7];
    logic [40:0]        phi_reg [7];
    logic               png_reg [7];
    logic               mc3_reg;

    always_comb
    begin
        logic [31:0] ma;
        logic [40:0] mb;
        ca[0] = pc_reg;    cb[0] = crd2_reg.dx;
        ca[1] = ps_reg;    cb[1] = crd2_reg.dy;
        ca[2] = sdec2_reg; cb[2] = crd2_reg.dz;
        ca[3] = ps_reg;    cb[3] = crd2_reg.dx;
        ca[4] = pc_reg;    cb[4] = crd2_reg.dy;
        ca[5] = ps_reg;    cb[5] = 41'(crd2_reg.ex);
        ca[6] = pc_reg;    cb[6] = 41'(crd2_reg.ey);
        for (int k = 0; k < 7; k++)
        begin
            ma = mag33(ca[k]);
            mb = mag41(cb[k]);
            plo_next[k] = 64'(ma) * 64'(mb[31:0]);
            phi_next[k] = 41'(ma) * 41'(mb[40:32]);
            png_next[k] = ca[k][32] ^ cb[k][40];
        end
    end

    // stage p4: terms rounded to 2^-24 m
    logic signed [50:0] trm_next [7];
    logic signed [50:0] trm_reg [7];
    logic               mc4_reg;

    always_comb
    begin
        logic [72:0] s;
        logic signed [50:0] r;
        for (int k = 0; k < 7; k++)
        begin
            s = 73'(plo_reg[k]) + {phi_reg[k], 32'b0} + 73'(23'h40_0000);
            r = $signed({1'b0, s[72:23]});
            trm_next[k] = png_reg[k] ? -r : r;
        end
    end

    // stage p5: w and the two rate sums
    logic signed [52:0] w_reg, uw_reg, uv_reg;
    logic               mc5_reg;

    // stage p6: omega and scale partial products
    logic [56:0] wlo_reg;
    logic [55:0] whi_reg;
    logic        wng_reg;
    logic [60:0] dlo_reg, vlo_reg;
    logic [59:0] dhi_reg, vhi_reg;
    logic        dng_reg, vng_reg, mc6_reg;
    logic [52:0] mw, mu, mv;

    assign mw = mag53(w_reg);
    assign mu = mag53(uw_reg);
    assign mv = mag53(uv_reg);

    // stage p7: w rate, end point velocity, scaled delay numerator
    logic [86:0] du_sum, vu_sum;
    logic signed [40:0] dr_mag, vr_mag;
    logic [82:0] pw_reg;
    logic        wng7_reg;
    logic signed [40:0] dw_reg, vel_reg;

    assign du_sum = 87'(dlo_reg) + {dhi_reg, 27'b0} + 87'(47'h4000_0000_0000);
    assign vu_sum = 87'(vlo_reg) + {vhi_reg, 27'b0} + 87'(47'h4000_0000_0000);
    assign dr_mag = $signed({1'b0, du_sum[86:47]});
    assign vr_mag = $signed({1'b0, vu_sum[86:47]});

    // stage p8: denominator, rate scale partials
    logic signed [54:0] den_full;
    logic [40:0]        mr;
    logic [DW-1:0]      d_reg;
    logic [82:0]        pw8_reg;
    logic               wng8_reg;
    logic [50:0]        rlo_reg;
    logic [49:0]        rhi_reg;
    logic               rng_reg;

    assign den_full = $signed({2'b0, bgd_pkg::LIGHT_Q24}) - 55'(vel_reg);
    assign mr       = mag41(dw_reg);

    // stage p9: dividends with half divisor added
    logic [98:0]   nw_reg;
    logic [94:0]   nr_reg;
    logic          wng9_reg, rng9_reg;
    logic [DW-1:0] d9_reg;
    logic [70:0]   pr_sum;

    assign pr_sum = 71'(rlo_reg) + {rhi_reg, 21'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // p1
            pms_reg   <= 64'(mag33(cdec)) * 64'(mag33(sha));
            pmc_reg   <= 64'(mag33(cdec)) * 64'(mag33(cha));
            ngs_reg   <= cdec[32] ^ sha[32];
            ngc_reg   <= cdec[32] ^ cha[32];
            sdec1_reg <= sdec;
            crd1_reg  <= crd_reg[SC-1];
            // p2
            ps_reg    <= ngs_reg ? -rs_mag : rs_mag;
            pc_reg    <= ngc_reg ? -rc_mag : rc_mag;
            sdec2_reg <= sdec1_reg;
            crd2_reg  <= crd1_reg;
            // p3
            for (int k = 0; k < 7; k++)
            begin
                plo_reg[k] <= plo_next[k];
                phi_reg[k] <= phi_next[k];
                png_reg[k] <= png_next[k];
            end
            mc3_reg <= crd2_reg.mc;
            // p4
            for (int k = 0; k < 7; k++)
            begin
                trm_reg[k] <= trm_next[k];
            end
            mc4_reg <= mc3_reg;
            // p5
            w_reg   <= 53'(trm_reg[0]) - 53'(trm_reg[1]) + 53'(trm_reg[2]);
            uw_reg  <= 53'(trm_reg[3]) + 53'(trm_reg[4]);
            uv_reg  <= 53'(trm_reg[5]) + 53'(trm_reg[6]);
            mc5_reg <= mc4_reg;
            // p6
            wlo_reg <= 57'(mw[26:0]) * 57'(bgd_pkg::GIGA);
            whi_reg <= 56'(mw[52:27]) * 56'(bgd_pkg::GIGA);
            wng_reg <= w_reg[52];
            dlo_reg <= 61'(mu[26:0]) * 61'(bgd_pkg::OMEGA_Q47);
            dhi_reg <= 60'(mu[52:27]) * 60'(bgd_pkg::OMEGA_Q47);
            dng_reg <= uw_reg[52];
            vlo_reg <= 61'(mv[26:0]) * 61'(bgd_pkg::OMEGA_Q47);
            vhi_reg <= 60'(mv[52:27]) * 60'(bgd_pkg::OMEGA_Q47);
            vng_reg <= uv_reg[52];
            mc6_reg <= mc5_reg;
            // p7: rate is minus omega times the sum
            pw_reg   <= 83'(wlo_reg) + {whi_reg, 27'b0};
            wng7_reg <= wng_reg;
            dw_reg   <= dng_reg ? dr_mag : -dr_mag;
            if (mc6_reg)
            begin
                vel_reg <= vng_reg ? vr_mag : -vr_mag;
            end
            else
            begin
                vel_reg <= '0;
            end
            // p8
            d_reg    <= den_full[DW-1:0];
            pw8_reg  <= pw_reg;
            wng8_reg <= wng7_reg;
            rlo_reg  <= 51'(mr[20:0]) * 51'(bgd_pkg::GIGA);
            rhi_reg  <= 50'(mr[40:21]) * 50'(bgd_pkg::GIGA);
            rng_reg  <= dw_reg[40];
            // p9: scales are 1e9 * 2^16 and 1e9 * 2^24
            nw_reg   <= {pw8_reg, 16'b0} + 99'(d_reg[DW-1:1]);
            nr_reg   <= {pr_sum, 24'b0} + 95'(d_reg[DW-1:1]);
            wng9_reg <= wng8_reg;
            rng9_reg <= rng_reg;
            d9_reg   <= d_reg;
        end
    end

    // dividers
    logic [QB-1:0] qw, qr;
    logic          qw_neg, qr_neg;

    bgd_divider #(
        .NW (99),
        .QB (QB),
        .DW (DW)
    ) u_div_dly (
        .clk     (clk),
        .en      (en),
        .num     (nw_reg),
        .den     (d9_reg),
        .neg_in  (wng9_reg),
        .quo     (qw),
        .neg_out (qw_neg)
    );

    bgd_divider #(
        .NW (95),
        .QB (QB),
        .DW (DW)
    ) u_div_rte (
        .clk     (clk),
        .en      (en),
        .num     (nr_reg),
        .den     (d9_reg),
        .neg_in  (rng9_reg),
        .quo     (qr),
        .neg_out (qr_neg)
    );

    // output stage: sign flip and clipping
    logic signed [47:0] dly_val, rte_val;
    logic signed [42:0] dly_next;
    logic signed [36:0] rte_next;
    logic               sat_next;
    logic signed [42:0] dly_reg;
    logic signed [36:0] rte_reg;
    logic               sat_reg;

    always_comb
    begin
        // a negative numerator gives a positive delay
        dly_val  = qw_neg ? $signed({1'b0, qw}) : -$signed({1'b0, qw});
        rte_val  = qr_neg ? $signed({1'b0, qr}) : -$signed({1'b0, qr});
        sat_next = 1'b0;
        priority if (dly_val > DLY_MAX)
        begin
            dly_next = DLY_MAX[42:0];
            sat_next = 1'b1;
        end
        else if (dly_val < DLY_MIN)
        begin
            dly_next = DLY_MIN[42:0];
            sat_next = 1'b1;
        end
        else
        begin
            dly_next = dly_val[42:0];
        end
        priority if (rte_val > RTE_MAX)
        begin
            rte_next = RTE_MAX[36:0];
            sat_next = 1'b1;
        end
        else if (rte_val < RTE_MIN)
        begin
            rte_next = RTE_MIN[36:0];
            sat_next = 1'b1;
        end
        else
        begin
            rte_next = rte_val[36:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg <= dly_next;
            rte_reg <= rte_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tdata = {7'b0, sat_reg, rte_reg, dly_reg};

    // checks
    a_sat_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sat_reg |->
            (dly_reg == DLY_MAX[42:0]) || (dly_reg == DLY_MIN[42:0]) ||
            (rte_reg == RTE_MAX[36:0]) || (rte_reg == RTE_MIN[36:0]))
        else $error("saturated flag without a clipped output");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[0]) && $stable(vld_reg[DEN_STG]) && $stable(m_tvalid))
        else $error("pipeline moved during a stall");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DEN_STG] |-> d_reg > (bgd_pkg::LIGHT_Q24 >> 1))
        else $error("denominator out of range");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item not tracked");

endmodule

### bench/baseline_geometric_delay_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baseline_geometric_delay_test
// self-checking bench for the baseline geometric delay pipeline
// ----------------------------------------------------------------------------
// Drives hour angle, declination, baseline end point and origin items into
// the block. A bit-exact predictor works out the expected delay, rate and
// saturation flag of each accepted item. Results are compared in order.
// The first items are directed: field extremes, quadrant and octant edges,
// poles and saturation. After them come random items. Both sides idle at
// random, with stretches where neither side idles.
// ----------------------------------------------------------------------------
module baseline_geometric_delay_test;

    typedef struct {
        logic [31:0]        hour_angle;
        logic [31:0]        declination;
        logic signed [39:0] end_x, end_y, end_z;
        logic signed [39:0] origin_x, origin_y, origin_z;
        logic               motion_correct;
    } pointing_t;

    typedef struct {
        logic [42:0] delay_ns;
        logic [36:0] delay_rate;
        logic        saturated;
    } delay_t;

    localparam longint DELAY_SCALE = 64'd65536000000000;
    localparam longint RATE_SCALE  = 64'd16777216000000000;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     RANDOM_ITEMS = 730;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [311:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;

    // no idling on either side while set
    bit quiet = 1'b0;
    int cycles = 0;

    always #1 clk = ~clk;

    baseline_geometric_delay dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // delay predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? -longint'(v) : v;
    endfunction

    // product divided by 2^s, rounded half away from zero
    function automatic longint mul_round(longint a, longint b, int s);
        logic [127:0] prod;
        longint unsigned r;
        prod = 128'(magnitude(a)) * 128'(magnitude(b));
        prod = prod + (128'd1 << (s - 1));
        r = 64'(prod >> s);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // round(num * k / den), zero when den is zero or the quotient would not fit 64 bits
    function automatic longint scaled_quotient(longint num, longint unsigned k,
                                               longint unsigned den);
        logic [127:0] prod;
        longint unsigned q;
        if (den == 0)
            return 0;
        prod = 128'(magnitude(num)) * 128'(k) + 128'(den >> 1);
        if ((prod >> 64) >= 128'(den))
            return 0;
        q = 64'(prod / 128'(den));
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    // q31 sine and cosine of an angle in 2^-32 turn
    function automatic void turn_sincos(logic [31:0] t, output longint sn,
                                        output longint cs);
        int unsigned sin_div [4] = '{72, 42, 20, 6};
        int unsigned cos_div [5] = '{90, 56, 30, 12, 2};
        longint unsigned u, y, x, x2, p, s0, c0;
        longint a, b;
        bit swap;
        u = t[29:0];
        swap = u > 64'h2000_0000;
        y = swap ? 64'h4000_0000 - u : u;
        x = (y * longint'(bgd_pkg::PI_Q30)) >> 30;
        x2 = (x * x) >> 31;
        p = 64'h8000_0000 - x2 / sin_div[0];
        for (int i = 1; i < 4; i++)
            p = 64'h8000_0000 - ((x2 * p) >> 31) / sin_div[i];
        s0 = (x * p) >> 31;
        p = 64'h8000_0000 - x2 / cos_div[0];
        for (int i = 1; i < 5; i++)
            p = 64'h8000_0000 - ((x2 * p) >> 31) / cos_div[i];
        c0 = p;
        a = swap ? c0 : s0;
        b = swap ? s0 : c0;
        case (t[31:30])
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
    endfunction

    // w rate in 2^-24 m/s
    function automatic longint w_rate(longint ps, longint pc, longint x, longint y);
        longint u;
        u = mul_round(ps, x, 23) + mul_round(pc, y, 23);
        return -mul_round(u, longint'(bgd_pkg::OMEGA_Q47), 47);
    endfunction

    function automatic longint clip_to(longint v, int w, ref bit flag);
        longint hi, lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin flag = 1'b1; return hi; end
        if (v < lo) begin flag = 1'b1; return lo; end
        return v;
    endfunction

    function automatic delay_t predict_delay(pointing_t it);
        longint sha, cha, sdec, cdec, ps, pc, dx, dy, dz, w, dw, vel, den;
        longint dl, rt;
        bit sat;
        delay_t r;
        sat = 1'b0;
        vel = 0;
        dx = longint'(it.end_x) - longint'(it.origin_x);
        dy = longint'(it.end_y) - longint'(it.origin_y);
        dz = longint'(it.end_z) - longint'(it.origin_z);
        turn_sincos(it.hour_angle, sha, cha);
        turn_sincos(it.declination, sdec, cdec);
        ps = mul_round(cdec, sha, 31);
        pc = mul_round(cdec, cha, 31);
        w = mul_round(pc, dx, 23) - mul_round(ps, dy, 23) + mul_round(sdec, dz, 23);
        dw = w_rate(ps, pc, dx, dy);
        if (it.motion_correct)
            vel = w_rate(ps, pc, longint'(it.end_x), longint'(it.end_y));
        den = longint'(bgd_pkg::LIGHT_Q24) - vel;
        if (den > 0) begin
            dl = -scaled_quotient(w, DELAY_SCALE, den);
            rt = -scaled_quotient(dw, RATE_SCALE, den);
        end
        else begin
            dl = 0;
            rt = 0;
        end
        dl = clip_to(dl, 43, sat);
        rt = clip_to(rt, 37, sat);
        r.delay_ns = dl[42:0];
        r.delay_rate = rt[36:0];
        r.saturated = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard: expected results in order of acceptance
    // ------------------------------------------------------------------
    class delay_scoreboard;
        delay_t expected_delays[$];
        int errors = 0;

        function int pending();
            return expected_delays.size();
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("error at %0t: %s got %h expected %h", $realtime, what, got, want);
        endtask

        task note_item(pointing_t it);
            expected_delays.push_back(predict_delay(it));
        endtask

        task check_result(logic [87:0] data);
            delay_t want;
            if (expected_delays.size() == 0) begin
                report("unexpected result", 64'(data), 64'd0);
                return;
            end
            want = expected_delays.pop_front();
            if (data[42:0] !== want.delay_ns)
                report("delay_ns", 64'(data[42:0]), 64'(want.delay_ns));
            if (data[79:43] !== want.delay_rate)
                report("delay_rate", 64'(data[79:43]), 64'(want.delay_rate));
            if (data[80] !== want.saturated)
                report("saturated", 64'(data[80]), 64'(want.saturated));
        endtask
    endclass

    delay_scoreboard sb = new();

    // ------------------------------------------------------------------
    // handshakes are sampled mid-cycle so the edge holds no race
    // ------------------------------------------------------------------
    bit           in_fire, out_fire;
    logic [311:0] in_word;
    logic [87:0]  out_word;

    always @(negedge clk)
    begin
        in_fire  <= rst_n && s_tvalid && s_tready;
        out_fire <= rst_n && m_tvalid && m_tready;
        in_word  <= s_tdata;
        out_word <= m_tdata;
    end

    always @(posedge clk)
    begin
        pointing_t it;
        cycles++;
        if (in_fire) begin
            it.hour_angle     = in_word[31:0];
            it.declination    = in_word[63:32];
            it.end_x          = in_word[103:64];
            it.end_y          = in_word[143:104];
            it.end_z          = in_word[183:144];
            it.origin_x       = in_word[223:184];
            it.origin_y       = in_word[263:224];
            it.origin_z       = in_word[303:264];
            it.motion_correct = in_word[304];
            sb.note_item(it);
        end
        if (out_fire)
            sb.check_result(out_word);
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls before each item
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        wait (rst_n);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_tvalid);
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_item(pointing_t it);
        int n;
        n = draw_gap();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, it.motion_correct, it.origin_z, it.origin_y, it.origin_x,
                    it.end_z, it.end_y, it.end_x, it.declination, it.hour_angle};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    task automatic send_fields(logic [31:0] ha, logic [31:0] dec,
                               logic [39:0] ex, logic [39:0] ey, logic [39:0] ez,
                               logic [39:0] ox, logic [39:0] oy, logic [39:0] oz,
                               logic mc);
        pointing_t it;
        it.hour_angle = ha;
        it.declination = dec;
        it.end_x = ex;
        it.end_y = ey;
        it.end_z = ez;
        it.origin_x = ox;
        it.origin_y = oy;
        it.origin_z = oz;
        it.motion_correct = mc;
        send_item(it);
    endtask

    function automatic logic [39:0] any_coord();
        return 40'({$urandom, $urandom});
    endfunction

    // coordinate drawn from the extremes, zero, a short baseline or anything
    function automatic logic [39:0] pick_coord(int kind);
        case (kind)
            0: return any_coord();
            1: return 40'(signed'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
            default:
                case ($urandom_range(0, 3))
                    0: return 40'h7F_FFFF_FFFF;
                    1: return 40'h80_0000_0000;
                    2: return 40'h0;
                    default: return any_coord();
                endcase
        endcase
    endfunction

    localparam logic [39:0] C_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] C_MIN = 40'h80_0000_0000;

    initial
    begin
        int kind;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero baseline, quadrant and octant edges, poles
        send_fields(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_fields(32'h4000_0000, 0, C_MAX, 0, 0, C_MIN, 0, 0, 1'b1);
        send_fields(32'h8000_0000, 32'h4000_0000, 0, 0, C_MAX, 0, 0, C_MIN, 1'b0);
        send_fields(32'hC000_0000, 32'hC000_0000, 0, 0, C_MIN, 0, 0, C_MAX, 1'b1);
        send_fields(32'h2000_0000, 32'h2000_0000, 40'd1 << 30, 40'd1 << 29, 40'd1 << 28,
                    0, 0, 0, 1'b0);
        send_fields(32'h2000_0001, 32'hE000_0001, 40'd1 << 30, 40'd1 << 29,
                    40'd1 << 28, 0, 0, 0, 1'b1);
        send_fields(32'h1FFF_FFFF, 32'h1FFF_FFFF, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                    C_MAX, 1'b0);
        // declination beyond a quarter turn
        send_fields(32'hFFFF_FFFF, 32'h7FFF_FFFF, C_MAX, C_MAX, C_MAX, 0, 0, 0, 1'b1);
        send_fields(32'h6000_0000, 32'h8000_0000, C_MAX, C_MIN, C_MAX, 0, 0, 0, 1'b0);
        send_fields(32'hA000_0000, 32'h4000_0001, 40'h12_3456_789A, 0, 40'h1, 0, 0, 0,
                    1'b1);
        // saturation of the rate, with and without motion correction
        send_fields(32'h4000_0000, 0, C_MAX, C_MAX, 0, C_MIN, C_MIN, 0, 1'b0);
        send_fields(32'h4000_0000, 0, C_MAX, C_MAX, 0, C_MIN, C_MIN, 0, 1'b1);
        send_fields(32'hC000_0000, 0, C_MIN, C_MIN, 0, C_MAX, C_MAX, 0, 1'b1);
        send_fields(32'h0000_0000, 0, C_MAX, C_MIN, 0, C_MIN, C_MAX, 0, 1'b0);
        send_fields(32'h0000_0001, 32'h0000_0001, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN,
                    C_MIN, 1'b1);
        send_fields(32'h8000_0000, 0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b0);
        send_fields(32'h3000_0000, 32'hF000_0000, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                    C_MIN, 1'b1);

        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 250 && i < 350) || (i >= 600 && i < 640);
            if (i == 450) begin
                // hold off until the pipeline has drained
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            kind = $urandom_range(0, 19) < 11 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
            send_fields($urandom, $urandom, pick_coord(kind), pick_coord(kind),
                        pick_coord(kind), pick_coord(kind), pick_coord(kind),
                        pick_coord(kind), 1'($urandom_range(0, 1)));
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
src/bgd_pkg.sv
src/bgd_horner.sv
src/bgd_sincos.sv
src/bgd_divider.sv
src/baseline_geometric_delay.sv
bench/baseline_geometric_delay_test.sv
